[design/rvtm_pkg.sv]
// Package for the rail voltage trim monitor.
// Holds widths, reset values, constants and code types shared by the divider and the top level.
// No dependencies.
package rvtm_pkg;

  localparam int unsigned ADC_BITS   = 12;
  localparam int unsigned DAC_BITS   = 12;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned VDIV_W     = 12;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned LIMIT_W    = 20;
  localparam int unsigned MV10_W     = 23;
  localparam int unsigned CUR_W      = 25;
  localparam int unsigned CONST_W    = 14;
  localparam int unsigned MUL_B_W    = (ADC_BITS > BAND_W) ? ADC_BITS : BAND_W;
  localparam int unsigned DIVR_W     = (ADC_BITS > CONST_W) ? ADC_BITS : CONST_W;
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_CYC    = WORD_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYC);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned IN_DATA_W  = ((4 * ADC_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned OUT_DATA_W = ((DAC_BITS + MV10_W + CUR_W + 4 + 7) / 8) * 8;

  localparam int unsigned V10_TARGET_MV = 10000;
  localparam int unsigned V5_TARGET_MV  = 5000;
  localparam int unsigned PCT_SCALE     = 1000;
  localparam int unsigned C5_DIVISOR    = 10000;
  localparam int unsigned CUR_DIVISOR   = 22;
  localparam int unsigned V5_BAND       = 100;

  localparam logic [SCALE_W-1:0]  RST_SCALE_NUM   = SCALE_W'(12000000);
  localparam logic [VDIV_W-1:0]   RST_V10_DIVIDER = VDIV_W'(909);
  localparam logic [BAND_W-1:0]   RST_DEAD_BAND   = BAND_W'(5);
  localparam logic [BAND_W-1:0]   RST_STABLE_BAND = BAND_W'(50);
  localparam logic [DAC_BITS-1:0] RST_DAC_MIN     = DAC_BITS'(12'h290);
  localparam logic [DAC_BITS-1:0] RST_DAC_MAX     = DAC_BITS'(12'h2ff);
  localparam logic [LIMIT_W-1:0]  RST_OC_LIMIT    = LIMIT_W'(20000);
  localparam logic [DAC_BITS-1:0] RST_DAC_CODE    = DAC_BITS'(12'h2d0);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SCALE_NUM   = 3'd0,
    CFG_V10_DIVIDER = 3'd1,
    CFG_DEAD_BAND   = 3'd2,
    CFG_STABLE_BAND = 3'd3,
    CFG_DAC_MIN     = 3'd4,
    CFG_DAC_MAX     = 3'd5,
    CFG_V5_ENABLE   = 3'd6,
    CFG_OC_LIMIT    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_SCALE = 3'd0,
    OP_MV10  = 3'd1,
    OP_DEV10 = 3'd2,
    OP_C5    = 3'd3,
    OP_C5CL  = 3'd4,
    OP_DEV5  = 3'd5,
    OP_CUR   = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [ADC_BITS-1:0] v5cl_reading;
    logic [ADC_BITS-1:0] v5_reading;
    logic [ADC_BITS-1:0] v10_reading;
    logic [ADC_BITS-1:0] vref_reading;
  } in_data_t;

  typedef struct packed {
    logic [CUR_W-1:0]    v5_current;
    logic                v5_overcurrent_flag;
    logic                v5_is_stable;
    logic                v10_is_stable;
    logic [MV10_W-1:0]   v10_millivolts;
    logic                dac_written;
    logic [DAC_BITS-1:0] dac_code_out;
  } out_data_t;

endpackage

[design/rvtm_div.sv]
// Iterative unsigned divider, several quotient bits per cycle, shared by all sequencer steps.
// Depends on rvtm_pkg.
module rvtm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rvtm_pkg::WORD_W-1:0]  dividend_i,
  input  logic [rvtm_pkg::DIVR_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [rvtm_pkg::WORD_W-1:0]  quotient_o
);
  import rvtm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [WORD_W-1:0]    quo_q, quo_d;
  logic [DIVR_W:0]      rem_q, rem_d;
  logic [DIVR_W-1:0]    dvs_q;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_STEP; i++) begin
      rem_d = {rem_d[DIVR_W-1:0], quo_d[WORD_W-1]};
      quo_d = {quo_d[WORD_W-2:0], 1'b0};
      if (rem_d >= {1'b0, dvs_q}) begin
        rem_d    = rem_d - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(DIV_CYC - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYC - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/rail_voltage_trim_monitor.sv]
// Rail voltage trim monitor: top level with sequencer, shared multiplier and config registers.
// Each division step passes through ST_LOAD, which starts the shared divider, and ST_WAIT,
// which holds until the divider's done strobe. Items with neither due nor force_req set skip
// the division steps; the 5V steps run only while the 5V check is enabled. Transactions are
// handled one at a time: a new one is accepted only in ST_IDLE, and output back-pressure holds ST_OUT.
// Reset (rst_ni, asynchronous): config to defaults, DAC code 0x2d0, stable, overcurrent and valid flags clear.
module rail_voltage_trim_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // vref_reading, v10_reading, v5_reading, v5cl_reading
  input  logic [rvtm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // due, force_req
  input  logic [rvtm_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // dac_code_out, dac_written, v10_millivolts, v10_is_stable, v5_is_stable,
  // v5_overcurrent_flag, v5_current
  output logic [rvtm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // evaluated
  output logic [rvtm_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [rvtm_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [rvtm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import rvtm_pkg::*;

  state_e               state_q;
  op_e                  op_q;

  logic [SCALE_W-1:0]   scale_num_q;
  logic [VDIV_W-1:0]    v10_div_q;
  logic [BAND_W-1:0]    dead_band_q;
  logic [BAND_W-1:0]    stable_band_q;
  logic [DAC_BITS-1:0]  dac_min_q;
  logic [DAC_BITS-1:0]  dac_max_q;
  logic                 v5_en_q;
  logic [LIMIT_W-1:0]   oc_limit_q;

  logic [DAC_BITS-1:0]  dac_code_q;
  logic                 v10_ok_q;
  logic                 v5_ok_q;
  logic                 v5_over_q;

  in_data_t             in_q;
  logic                 run_q;
  logic                 written_q;
  logic                 neg_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [WORD_W-1:0]    mv10_q;
  logic [WORD_W-1:0]    c5_q;
  logic [WORD_W-1:0]    c5cl_q;
  logic [WORD_W-1:0]    cur_q;

  logic                 out_valid_q;
  out_data_t            out_data_q;
  logic                 out_user_q;

  logic [WORD_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [WORD_W+MUL_B_W-1:0]  prod_full;
  logic [WORD_W-1:0]          prod;
  logic [WORD_W-1:0]          dividend;
  logic [DIVR_W-1:0]          divisor;
  logic                       neg_d;
  logic                       div_start;
  logic                       div_done;
  logic [WORD_W-1:0]          quot;

  logic                 in_fire;
  logic                 out_free;
  logic [DAC_BITS:0]    dac_up;
  logic [DAC_BITS:0]    dac_dn;
  logic                 up_ok;
  logic                 dn_ok;
  in_data_t             in_data;

  assign in_data   = in_data_t'(s_axis_tdata[4*ADC_BITS-1:0]);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign div_start = (state_q == ST_LOAD);

  assign s_axis_tready = (state_q == ST_IDLE);

  // operand select for the shared multiplier and divider
  always_comb begin
    mul_a    = WORD_W'(scale_q);
    mul_b    = MUL_B_W'(PCT_SCALE);
    dividend = '0;
    divisor  = DIVR_W'(C5_DIVISOR);
    neg_d    = 1'b0;
    unique case (op_q)
      OP_SCALE: begin
        divisor = (in_q.vref_reading != '0) ? DIVR_W'(in_q.vref_reading) : DIVR_W'(1);
      end
      OP_MV10: begin
        mul_b   = MUL_B_W'(in_q.v10_reading);
        divisor = (v10_div_q != '0) ? DIVR_W'(v10_div_q) : DIVR_W'(1);
      end
      OP_DEV10: begin
        mul_a   = WORD_W'(V10_TARGET_MV) - mv10_q;
        divisor = DIVR_W'(V10_TARGET_MV);
      end
      OP_C5: begin
        mul_b = MUL_B_W'(in_q.v5_reading);
      end
      OP_C5CL: begin
        mul_b = MUL_B_W'(in_q.v5cl_reading);
      end
      OP_DEV5: begin
        mul_a   = WORD_W'(V5_TARGET_MV) - c5cl_q;
        divisor = DIVR_W'(V5_TARGET_MV);
      end
      OP_CUR: begin
        mul_a   = c5_q - c5cl_q;
        divisor = DIVR_W'(CUR_DIVISOR);
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod_full = mul_a * mul_b;
    prod      = prod_full[WORD_W-1:0];
    unique case (op_q) inside
      OP_SCALE: dividend = WORD_W'(scale_num_q);
      OP_MV10:  dividend = prod;
      OP_CUR:   dividend = prod;
      OP_C5:    dividend = {prod[WORD_W-2:0], 1'b0};
      OP_C5CL:  dividend = {prod[WORD_W-2:0], 1'b0};
      OP_DEV10, OP_DEV5: begin
        neg_d    = prod[WORD_W-1];
        dividend = neg_d ? (WORD_W'(0) - prod) : prod;
      end
      default:  dividend = '0;
    endcase
  end

  rvtm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign dac_up = {1'b0, dac_code_q} + 1'b1;
  assign dac_dn = {1'b0, dac_code_q} - 1'b1;
  assign up_ok  = (dac_up >= {1'b0, dac_min_q}) && (dac_up <= {1'b0, dac_max_q});
  assign dn_ok  = (dac_code_q != '0) && (dac_dn >= {1'b0, dac_min_q})
                  && (dac_dn <= {1'b0, dac_max_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_SCALE;
      scale_num_q   <= RST_SCALE_NUM;
      v10_div_q     <= RST_V10_DIVIDER;
      dead_band_q   <= RST_DEAD_BAND;
      stable_band_q <= RST_STABLE_BAND;
      dac_min_q     <= RST_DAC_MIN;
      dac_max_q     <= RST_DAC_MAX;
      v5_en_q       <= 1'b1;
      oc_limit_q    <= RST_OC_LIMIT;
      dac_code_q    <= RST_DAC_CODE;
      v10_ok_q      <= 1'b0;
      v5_ok_q       <= 1'b0;
      v5_over_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_SCALE_NUM:   scale_num_q   <= cfg_wdata_i[SCALE_W-1:0];
          CFG_V10_DIVIDER: v10_div_q     <= cfg_wdata_i[VDIV_W-1:0];
          CFG_DEAD_BAND:   dead_band_q   <= cfg_wdata_i[BAND_W-1:0];
          CFG_STABLE_BAND: stable_band_q <= cfg_wdata_i[BAND_W-1:0];
          CFG_DAC_MIN:     dac_min_q     <= cfg_wdata_i[DAC_BITS-1:0];
          CFG_DAC_MAX:     dac_max_q     <= cfg_wdata_i[DAC_BITS-1:0];
          CFG_V5_ENABLE:   v5_en_q       <= cfg_wdata_i[0];
          CFG_OC_LIMIT:    oc_limit_q    <= cfg_wdata_i[LIMIT_W-1:0];
          default:         v5_en_q       <= v5_en_q;
        endcase
      end

      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q    <= OP_SCALE;
            state_q <= (s_axis_tuser[0] || s_axis_tuser[1]) ? ST_LOAD : ST_OUT;
          end
        end
        ST_LOAD: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            unique case (op_q)
              OP_SCALE: begin
                op_q    <= OP_MV10;
                state_q <= ST_LOAD;
              end
              OP_MV10: begin
                op_q    <= OP_DEV10;
                state_q <= ST_LOAD;
              end
              OP_DEV10: begin
                if (quot > WORD_W'(dead_band_q)) begin
                  if (neg_q) begin
                    if (up_ok) dac_code_q <= dac_up[DAC_BITS-1:0];
                  end else begin
                    if (dn_ok) dac_code_q <= dac_dn[DAC_BITS-1:0];
                  end
                  v10_ok_q <= !(quot > WORD_W'(stable_band_q));
                end
                if (v5_en_q) begin
                  op_q    <= OP_C5;
                  state_q <= ST_LOAD;
                end else begin
                  v5_ok_q <= 1'b1;
                  state_q <= ST_OUT;
                end
              end
              OP_C5: begin
                op_q    <= OP_C5CL;
                state_q <= ST_LOAD;
              end
              OP_C5CL: begin
                op_q    <= OP_DEV5;
                state_q <= ST_LOAD;
              end
              OP_DEV5: begin
                v5_ok_q <= !(quot > WORD_W'(V5_BAND));
                if (c5_q > c5cl_q) begin
                  op_q    <= OP_CUR;
                  state_q <= ST_LOAD;
                end else begin
                  v5_over_q <= (oc_limit_q == '0);
                  state_q   <= ST_OUT;
                end
              end
              OP_CUR: begin
                v5_over_q <= (quot >= WORD_W'(oc_limit_q));
                state_q   <= ST_OUT;
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q      <= in_data;
      run_q     <= s_axis_tuser[0] || s_axis_tuser[1];
      written_q <= 1'b0;
      mv10_q    <= '0;
      cur_q     <= '0;
    end
    if (state_q == ST_LOAD) begin
      neg_q <= neg_d;
    end
    if ((state_q == ST_WAIT) && div_done) begin
      unique case (op_q)
        OP_SCALE: scale_q <= quot[SCALE_W-1:0];
        OP_MV10:  mv10_q  <= quot;
        OP_DEV10: begin
          if (quot > WORD_W'(dead_band_q)) begin
            written_q <= neg_q ? up_ok : dn_ok;
          end
        end
        OP_C5:    c5_q    <= quot;
        OP_C5CL:  c5cl_q  <= quot;
        OP_CUR:   cur_q   <= quot;
        default:  neg_q   <= neg_q;
      endcase
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_user_q                     <= run_q;
      out_data_q.dac_code_out        <= dac_code_q;
      out_data_q.dac_written         <= written_q;
      out_data_q.v10_millivolts      <= mv10_q[MV10_W-1:0];
      out_data_q.v10_is_stable       <= v10_ok_q;
      out_data_q.v5_is_stable        <= v5_ok_q;
      out_data_q.v5_overcurrent_flag <= v5_over_q;
      out_data_q.v5_current          <= cur_q[CUR_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_data_q);
  assign m_axis_tuser  = OUT_USER_W'(out_user_q);

endmodule
